// File: hw/rtl/i2cm_pkg.sv
// Shared types and constants for the I2C master byte engine.
// No dependencies; the modules in hw/rtl refer to this package by scoped names.
package i2cm_pkg;

    // Command codes, which are also the internal operation codes.
    typedef enum logic [2:0] {
        OP_IDLE  = 3'd0,
        OP_START = 3'd1,
        OP_STOP  = 3'd2,
        OP_WRITE = 3'd3,
        OP_READ  = 3'd4
    } op_t;

    localparam logic [3:0]  LAST_DATA_BIT     = 4'd7;
    localparam logic [3:0]  TAIL_SLOT         = 4'd9;
    localparam logic [1:0]  LAST_PHASE        = 2'd2;
    localparam logic [15:0] PHASE_TICKS_RESET = 16'd8;

    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] tx_byte;
        logic       send_ack;
        logic       sda_in;
    } item_t;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       nack_seen;
    } result_t;

endpackage

// File: hw/rtl/i2cm_in_if.sv
// Valid/ready channel that carries one tick transaction into the engine.
// Depends on nothing; payload fields match i2cm_pkg::item_t.
interface i2cm_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] mode;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;

    modport source (output valid, output mode, output tx_byte, output send_ack,
                    output sda_in, input ready);
    modport sink   (input valid, input mode, input tx_byte, input send_ack,
                    input sda_in, output ready);
endinterface

// File: hw/rtl/i2cm_out_if.sv
// Valid/ready channel that carries one result transaction out of the engine.
// Depends on nothing; payload fields match i2cm_pkg::result_t.
interface i2cm_out_if;
    logic       valid;
    logic       ready;
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       nack_seen;

    modport source (output valid, output scl_out, output sda_out, output busy_res,
                    output done_res, output rx_byte, output nack_seen, input ready);
    modport sink   (input valid, input scl_out, input sda_out, input busy_res,
                    input done_res, input rx_byte, input nack_seen, output ready);
endinterface

// File: hw/rtl/i2cm_in_stage.sv
// Input register of the I2C master byte engine.
// Depends on i2cm_pkg and i2cm_in_if.
module i2cm_in_stage (
    input  logic            clk,
    input  logic            rst_n,
    i2cm_in_if.sink         in_ch,
    input  logic            advance,
    output logic            item_valid,
    output i2cm_pkg::item_t item
);

    logic            valid_reg;
    i2cm_pkg::item_t item_reg;
    logic            take;

    // The register can take a new transaction when empty or when its content moves on.
    assign in_ch.ready = !valid_reg || advance;
    assign take        = in_ch.valid && in_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.mode     <= in_ch.mode;
            item_reg.tx_byte  <= in_ch.tx_byte;
            item_reg.send_ack <= in_ch.send_ack;
            item_reg.sda_in   <= in_ch.sda_in;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// File: hw/rtl/i2cm_engine.sv
// Bus sequencer state and its one-tick update for the I2C master byte engine.
// Depends on i2cm_pkg.
module i2cm_engine (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic [15:0]       phase_ticks,
    input  i2cm_pkg::item_t   item,
    output i2cm_pkg::result_t result
);

    i2cm_pkg::op_t op_reg,   op_next;
    logic [3:0]    bit_reg,  bit_next;
    logic [1:0]    ph_reg,   ph_next;
    logic [15:0]   tc_reg,   tc_next;
    logic [7:0]    tx_reg,   tx_next;
    logic [7:0]    rx_reg,   rx_next;
    logic          ack_reg,  ack_next;
    logic          nack_reg, nack_next;
    logic          scl_reg,  scl_next;
    logic          sda_reg,  sda_next;
    logic          done;
    logic          finish;
    logic [15:0]   limit;
    logic          phase_end;

    // A zero setting behaves as one tick per phase.
    assign limit     = (phase_ticks == 16'd0) ? 16'd1 : phase_ticks;
    assign phase_end = ({1'b0, tc_reg} + 17'd1) >= {1'b0, limit};

    always_comb
    begin
        op_next   = op_reg;
        bit_next  = bit_reg;
        ph_next   = ph_reg;
        tc_next   = tc_reg;
        tx_next   = tx_reg;
        rx_next   = rx_reg;
        ack_next  = ack_reg;
        nack_next = nack_reg;
        scl_next  = scl_reg;
        sda_next  = sda_reg;
        done      = 1'b0;
        finish    = 1'b0;

        // Commands are taken only while idle; unknown codes count as no command.
        if (op_reg == i2cm_pkg::OP_IDLE &&
            (item.mode == i2cm_pkg::OP_START || item.mode == i2cm_pkg::OP_STOP ||
             item.mode == i2cm_pkg::OP_WRITE || item.mode == i2cm_pkg::OP_READ))
        begin
            op_next  = i2cm_pkg::op_t'(item.mode);
            bit_next = 4'd0;
            ph_next  = 2'd0;
            tc_next  = 16'd0;
            if (item.mode == i2cm_pkg::OP_WRITE)
            begin
                tx_next = item.tx_byte;
            end
            if (item.mode == i2cm_pkg::OP_READ)
            begin
                ack_next = item.send_ack;
                rx_next  = 8'd0;
            end
        end

        // Drive the levels of the current phase.
        case (op_next)
            i2cm_pkg::OP_START:
            begin
                case (ph_next)
                    2'd0:    begin scl_next = 1'b1; sda_next = 1'b1; end
                    2'd1:    begin scl_next = 1'b1; sda_next = 1'b0; end
                    default: begin scl_next = 1'b0; sda_next = 1'b0; end
                endcase
            end
            i2cm_pkg::OP_STOP:
            begin
                case (ph_next)
                    2'd0:    begin scl_next = 1'b0; sda_next = 1'b0; end
                    2'd1:    begin scl_next = 1'b1; sda_next = 1'b0; end
                    default: begin scl_next = 1'b1; sda_next = 1'b1; end
                endcase
            end
            i2cm_pkg::OP_WRITE, i2cm_pkg::OP_READ:
            begin
                if (bit_next >= i2cm_pkg::TAIL_SLOT)
                begin
                    scl_next = 1'b0;
                    sda_next = 1'b1;
                end
                else
                begin
                    scl_next = ph_next[0];
                    if (bit_next <= i2cm_pkg::LAST_DATA_BIT)
                    begin
                        sda_next = (op_next == i2cm_pkg::OP_WRITE) ? tx_next[7] : 1'b1;
                    end
                    else
                    begin
                        sda_next = (op_next == i2cm_pkg::OP_READ) ? !ack_next : 1'b1;
                    end
                end
            end
            default:
            begin
                scl_next = scl_reg;
                sda_next = sda_reg;
            end
        endcase

        // Count ticks; at the end of a phase sample, shift and advance.
        if (op_next != i2cm_pkg::OP_IDLE)
        begin
            if (({1'b0, tc_next} + 17'd1) >= {1'b0, limit})
            begin
                tc_next = 16'd0;
                if (op_next == i2cm_pkg::OP_START || op_next == i2cm_pkg::OP_STOP)
                begin
                    if (ph_next >= i2cm_pkg::LAST_PHASE)
                    begin
                        finish = 1'b1;
                    end
                    else
                    begin
                        ph_next = ph_next + 2'd1;
                    end
                end
                else if (bit_next >= i2cm_pkg::TAIL_SLOT)
                begin
                    finish = 1'b1;
                end
                else if (ph_next == 2'd0)
                begin
                    ph_next = 2'd1;
                end
                else
                begin
                    if (bit_next <= i2cm_pkg::LAST_DATA_BIT)
                    begin
                        if (op_next == i2cm_pkg::OP_WRITE)
                        begin
                            tx_next = {tx_next[6:0], 1'b0};
                        end
                        else
                        begin
                            rx_next = {rx_next[6:0], item.sda_in};
                        end
                    end
                    else if (op_next == i2cm_pkg::OP_WRITE)
                    begin
                        nack_next = item.sda_in;
                    end
                    ph_next  = 2'd0;
                    bit_next = bit_next + 4'd1;
                end
            end
            else
            begin
                tc_next = tc_next + 16'd1;
            end
        end

        if (finish)
        begin
            op_next  = i2cm_pkg::OP_IDLE;
            bit_next = 4'd0;
            ph_next  = 2'd0;
            done     = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg   <= i2cm_pkg::OP_IDLE;
            bit_reg  <= 4'd0;
            ph_reg   <= 2'd0;
            tc_reg   <= 16'd0;
            tx_reg   <= 8'd0;
            rx_reg   <= 8'd0;
            ack_reg  <= 1'b0;
            nack_reg <= 1'b0;
            scl_reg  <= 1'b1;
            sda_reg  <= 1'b1;
        end
        else if (advance)
        begin
            op_reg   <= op_next;
            bit_reg  <= bit_next;
            ph_reg   <= ph_next;
            tc_reg   <= tc_next;
            tx_reg   <= tx_next;
            rx_reg   <= rx_next;
            ack_reg  <= ack_next;
            nack_reg <= nack_next;
            scl_reg  <= scl_next;
            sda_reg  <= sda_next;
        end
    end

    assign result.scl_out   = scl_next;
    assign result.sda_out   = sda_next;
    assign result.busy_res  = (op_next != i2cm_pkg::OP_IDLE);
    assign result.done_res  = done;
    assign result.rx_byte   = rx_next;
    assign result.nack_seen = nack_next;

    // The slot counter never runs past the tail slot.
    assert property (@(posedge clk) disable iff (!rst_n)
        bit_reg <= i2cm_pkg::TAIL_SLOT)
        else $error("bit slot counter past tail slot");

    // Sequencing counters rest at zero while idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (op_reg == i2cm_pkg::OP_IDLE) |-> (bit_reg == 4'd0 && ph_reg == 2'd0 && tc_reg == 16'd0))
        else $error("counters not cleared while idle");

    // Byte transfers only use the low and high phase of a slot.
    assert property (@(posedge clk) disable iff (!rst_n)
        (op_reg == i2cm_pkg::OP_WRITE || op_reg == i2cm_pkg::OP_READ) |-> (ph_reg <= 2'd1))
        else $error("byte transfer in illegal phase");

    // A finishing tick always leaves the engine idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && done) |=> (op_reg == i2cm_pkg::OP_IDLE))
        else $error("engine busy after done");

    // Within a phase the tick counter stays below the phase length.
    assert property (@(posedge clk) disable iff (!rst_n)
        (op_reg != i2cm_pkg::OP_IDLE) |-> !phase_end || ({1'b0, tc_reg} + 17'd1 == {1'b0, limit}))
        else $error("tick counter overran phase length");

endmodule

// File: hw/rtl/i2cm_out_stage.sv
// Result register of the I2C master byte engine.
// Depends on i2cm_pkg and i2cm_out_if.
module i2cm_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  i2cm_pkg::result_t result,
    output logic              free,
    i2cm_out_if.source        out_ch
);

    logic              valid_reg;
    i2cm_pkg::result_t result_reg;

    // Free when empty or when the held transaction is taken this cycle.
    assign free = !valid_reg || out_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (free)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

    assign out_ch.valid     = valid_reg;
    assign out_ch.scl_out   = result_reg.scl_out;
    assign out_ch.sda_out   = result_reg.sda_out;
    assign out_ch.busy_res  = result_reg.busy_res;
    assign out_ch.done_res  = result_reg.done_res;
    assign out_ch.rx_byte   = result_reg.rx_byte;
    assign out_ch.nack_seen = result_reg.nack_seen;

endmodule

// File: hw/rtl/i2c_master_byte_engine.sv
// Top level of the I2C master byte engine: input register, sequencer and result register.
// Depends on i2cm_pkg, i2cm_in_if, i2cm_out_if, i2cm_in_stage, i2cm_engine and i2cm_out_stage.
//
// This block is an I2C bus master that drives open-drain SCL and SDA one bus phase at a
// time, each phase lasting phase_ticks ticks (zero behaves as one). Every input transaction
// is one tick: it carries the sampled SDA level and, when the engine is idle, an optional
// command (start, stop, write byte with ack sampling, read byte with ACK or NACK). Every
// tick produces exactly one result transaction with the SCL and SDA drive levels, busy and
// done flags, the receive shift register and the last write's ack status. The block takes
// one tick per clock cycle while neither side stalls; a tick is held in the input register
// and its result in the result register. The rate is set by the sequencer, whose whole
// state (slot, phase and tick counters, shift registers) updates once per tick. Both sides
// may stall freely: the input register and the result register decouple the channels, and
// the sequencer only advances when its tick can move into the result register. The
// phase_ticks register is written through cfg_wr_en and cfg_wr_data and should only be
// changed while no tick is in flight.
module i2c_master_byte_engine (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    i2cm_in_if.sink     in_ch,
    i2cm_out_if.source  out_ch
);

    logic              item_valid;
    i2cm_pkg::item_t   item;
    i2cm_pkg::result_t result;
    logic              out_free;
    logic              advance;
    logic [15:0]       phase_ticks_reg;

    // A tick is processed when one is waiting and the result register can take its result.
    assign advance = item_valid && out_free;

    // Phase length register, reset to eight ticks per phase.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_ticks_reg <= i2cm_pkg::PHASE_TICKS_RESET;
        end
        else if (cfg_wr_en)
        begin
            phase_ticks_reg <= cfg_wr_data;
        end
    end

    i2cm_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    i2cm_engine u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .phase_ticks (phase_ticks_reg),
        .item        (item),
        .result      (result)
    );

    i2cm_out_stage u_out_stage (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (advance),
        .result (result),
        .free   (out_free),
        .out_ch (out_ch)
    );

endmodule
